### rtl/wsrp_pkg.sv
// Package with the shared types and constants of the waveform shift register player.
`default_nettype none

package wsrp_pkg;

    // Number of 64-bit words in the sample store.
    localparam int STORE_WORDS = 512;
    localparam int PTR_W       = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int WORD_W      = 64;
    localparam int LEN_W       = 10;
    localparam int PHASE_W     = 4;
    localparam int SIW_W       = 3;
    localparam int SLOT_W      = 12;
    localparam int SAMPLE_W    = 8;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // Command codes of an input transfer.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Phases of one sample: 0 to 7 are the four shifts, then latch high and latch low.
    localparam logic [PHASE_W-1:0] PH_FIRST    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_LATCH_HI = 4'd8;
    localparam logic [PHASE_W-1:0] PH_LATCH_LO = 4'd9;
    localparam logic [SIW_W-1:0]   SIW_LAST    = 3'd7;

    // Register index of play_length.
    localparam logic REG_PLAY_LENGTH = 1'b0;
    localparam logic [LEN_W-1:0] PLAY_LEN_RESET = 10'd512;

    typedef struct packed {
        logic                cmd;
        logic [SLOT_W-1:0]   slot;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic shift_clock;
        logic lane_a_data;
        logic lane_b_data;
        logic latch_strobe;
    } t_out_item;

    // One masked write into the sample store.
    typedef struct packed {
        logic              en;
        logic [PTR_W-1:0]  addr;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] data;
    } t_store_wr;

endpackage

`default_nettype wire

### rtl/wsrp_ram.sv
// Generic single-clock RAM with a bit-masked write port and a registered read port.
`default_nettype none

module wsrp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  wire                                        i_clk,
    input  wire                                        i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                           i_wmask,
    input  wire  [WIDTH-1:0]                           i_wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int b = 0; b < WIDTH; b++) begin
                if (i_wmask[b]) begin
                    r_mem[i_waddr][b] <= i_wdata[b];
                end
            end
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/wsrp_seq.sv
// Playback sequencer: phase and sample counters, holding word, store pointer and pin levels.
`default_nettype none

module wsrp_seq (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_tick,
    input  wire  wsrp_pkg::t_store_wr        i_wr,
    input  wire  [wsrp_pkg::LEN_W-1:0]       i_play_length,
    input  wire  [wsrp_pkg::WORD_W-1:0]      i_rdata,
    output logic [wsrp_pkg::PTR_W-1:0]       o_raddr,
    output wsrp_pkg::t_out_item              o_pins
);
    import wsrp_pkg::*;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [SIW_W-1:0]   r_siw, n_siw;
    logic [PTR_W-1:0]   r_ptr, n_ptr;
    logic [WORD_W-1:0]  r_hold, n_hold;
    t_store_wr          r_fwd;
    logic [PTR_W-1:0]   r_rd_addr;

    logic [PTR_W:0]     ptr_inc;
    logic [WORD_W-1:0]  fetched;
    logic [SAMPLE_W-1:0] cur;
    logic [1:0]         shift_idx;
    logic [1:0]         bit_sel;
    logic               load;

    // A write that landed at the same edge as the read is merged over the stale read data.
    always_comb begin
        if (r_fwd.en && (r_fwd.addr == r_rd_addr)) begin
            fetched = (i_rdata & ~r_fwd.mask) | (r_fwd.data & r_fwd.mask);
        end else begin
            fetched = i_rdata;
        end
    end

    always_comb begin
        cur = r_hold[r_siw*SAMPLE_W +: SAMPLE_W];
        if (r_phase < PH_LATCH_HI) begin
            shift_idx          = r_phase[2:1];
            o_pins.shift_clock = r_phase[0];
            o_pins.latch_strobe = 1'b0;
        end else begin
            shift_idx          = 2'd3;
            o_pins.shift_clock = 1'b1;
            o_pins.latch_strobe = (r_phase == PH_LATCH_HI);
        end
        bit_sel            = shift_idx + 2'd3;
        o_pins.lane_a_data = cur[{1'b0, bit_sel}];
        o_pins.lane_b_data = cur[{1'b1, bit_sel}];
    end

    assign load    = i_tick && (r_phase == PH_LATCH_LO) && (r_siw == SIW_LAST);
    assign ptr_inc = {1'b0, r_ptr} + 1'b1;
    assign o_raddr = r_ptr;

    always_comb begin
        n_phase = r_phase;
        n_siw   = r_siw;
        n_ptr   = r_ptr;
        n_hold  = r_hold;
        if (i_tick) begin
            if (r_phase == PH_LATCH_LO) begin
                n_phase = PH_FIRST;
                n_siw   = r_siw + 1'b1;
            end else begin
                n_phase = r_phase + 1'b1;
            end
        end
        if (load) begin
            n_hold = fetched;
            if ((32'(ptr_inc) >= 32'(i_play_length)) || (32'(ptr_inc) >= 32'(STORE_WORDS))) begin
                n_ptr = '0;
            end else begin
                n_ptr = ptr_inc[PTR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_siw   <= '0;
            r_ptr   <= '0;
            r_hold  <= '0;
            r_fwd   <= '0;
        end else begin
            r_phase <= n_phase;
            r_siw   <= n_siw;
            r_ptr   <= n_ptr;
            r_hold  <= n_hold;
            r_fwd   <= i_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_ptr;
    end

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_LATCH_LO)
        else $error("phase counter left its range");

    a_siw_moves_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_tick && (r_phase == PH_LATCH_LO)) |=> $stable(r_siw))
        else $error("sample index changed outside the end of a sample");

    a_ptr_moves_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !load |=> $stable(r_ptr))
        else $error("store pointer moved without a word load");

    a_ptr_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ptr) < 32'(STORE_WORDS))
        else $error("store pointer beyond the store");

endmodule

`default_nettype wire

### rtl/wsrp_outbuf.sv
// Two-entry output buffer: an output register plus a skid register.
`default_nettype none

module wsrp_outbuf (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire wsrp_pkg::t_out_item i_data,
    output logic                 o_space,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output wsrp_pkg::t_out_item  o_out_data
);
    import wsrp_pkg::*;

    logic      r_out_valid, n_out_valid;
    logic      r_skid_valid, n_skid_valid;
    t_out_item r_out_data, n_out_data;
    t_out_item r_skid_data, n_skid_data;
    logic      out_fire;

    assign out_fire    = r_out_valid && i_out_ready;
    assign o_space     = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_data   = r_out_data;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (out_fire) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || out_fire) begin
                n_out_data  = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid_data  = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while the output register is empty");

    a_skid_drains_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_ready) |=> (r_out_valid && (r_out_data == $past(r_skid_data))))
        else $error("skid entry not moved to the output register");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_ready) |=> r_skid_valid && $stable(r_skid_data))
        else $error("skid entry lost while stalled");

endmodule

`default_nettype wire

### rtl/waveform_shift_register_player_top.sv
// Top level of the waveform shift register player: register port, sample store and playback.
//
//  Channel   Direction  Handshake                      Payload
//  input     in         i_in_valid / o_in_ready        i_in_data  (cmd, slot, sample)
//  output    out        o_out_valid / i_out_ready      o_out_data (clock, lane A, lane B, latch)
//  config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata (play_length)
//
// The block takes one input transfer per clock while o_in_ready is high. A tick transfer pushes
// its pin levels into the output buffer; a write transfer produces nothing and lands in the
// store RAM at the next edge, where a word load in the following cycle sees it through a
// one-entry forward path. Reset clears the counters, the holding word and play_length (to
// 512); the store RAM is not cleared, so no clearing pass follows reset. A stalled output
// fills a two-entry buffer, and o_in_ready falls only when both entries are occupied.
`default_nettype none

module waveform_shift_register_player_top (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire  wsrp_pkg::t_in_item       i_in_data,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output wsrp_pkg::t_out_item            o_out_data,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [wsrp_pkg::PADDR_W-1:0]   paddr,
    input  wire  [wsrp_pkg::PDATA_W-1:0]   pwdata,
    output logic [wsrp_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import wsrp_pkg::*;

    logic [LEN_W-1:0]   r_play_length;
    logic               cfg_write;
    logic               in_fire;
    logic               tick;
    logic [8:0]         word_idx;
    t_store_wr          store_wr;
    logic [PTR_W-1:0]   raddr;
    logic [WORD_W-1:0]  rdata;
    t_out_item          pins;
    logic               space;

    // The register port never stalls. Only one register exists; paddr[2] high reads as zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play_length <= PLAY_LEN_RESET;
        end else if (cfg_write && (paddr[2] == REG_PLAY_LENGTH)) begin
            r_play_length <= pwdata[LEN_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_PLAY_LENGTH) begin
            prdata = {{(PDATA_W-LEN_W){1'b0}}, r_play_length};
        end else begin
            prdata = '0;
        end
    end

    // Both transfer kinds share the buffer-space check so the input side stays simple.
    assign o_in_ready = space;
    assign in_fire    = i_in_valid && o_in_ready;
    assign tick       = in_fire && (i_in_data.cmd == CMD_TICK);

    // A sample write becomes a byte-masked word write; words past the store are dropped.
    assign word_idx = i_in_data.slot[SLOT_W-1:3];

    always_comb begin
        store_wr.en   = in_fire && (i_in_data.cmd == CMD_WRITE)
                        && (32'(word_idx) < 32'(STORE_WORDS));
        store_wr.addr = PTR_W'(word_idx);
        store_wr.mask = {{(WORD_W-SAMPLE_W){1'b0}}, {SAMPLE_W{1'b1}}}
                        << {i_in_data.slot[2:0], 3'b000};
        store_wr.data = {(WORD_W/SAMPLE_W){i_in_data.sample}};
    end

    wsrp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_wr.en),
        .i_waddr (store_wr.addr),
        .i_wmask (store_wr.mask),
        .i_wdata (store_wr.data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // The sequencer keeps the RAM read port parked on the next word to load.
    wsrp_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (tick),
        .i_wr          (store_wr),
        .i_play_length (r_play_length),
        .i_rdata       (rdata),
        .o_raddr       (raddr),
        .o_pins        (pins)
    );

    wsrp_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (tick),
        .i_data      (pins),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
